>>> rtl/pifmt_pkg.sv
// ----------------------------------------------------------------------------
// pifmt_pkg
// types, codes and character constants shared by the integer field formatter
// ----------------------------------------------------------------------------
`default_nettype none

package pifmt_pkg;

    // conversion codes
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEXL = 3'd2;
    localparam logic [2:0] OP_HEXU = 3'd3;
    localparam logic [2:0] OP_CHAR = 3'd4;
    localparam logic [2:0] OP_PCT  = 3'd5;

    // field kinds after classification
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NUM  = 2'd1;
    localparam logic [1:0] KIND_CHAR = 2'd2;
    localparam logic [1:0] KIND_PCT  = 2'd3;

    // ascii
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    // most digits of a 32-bit value in any supported radix
    localparam int DIG_MAX = 10;
    // hard cap on width and precision
    localparam int LEN_CAP = 49;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
        logic        left_justify;
        logic        zero_pad;
        logic        force_plus;
        logic        space_sign;
        logic        alt_form;
        logic [5:0]  width;
        logic        has_precision;
        logic [5:0]  precision;
    } conv_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } result_t;

    // one laid-out field, ready for character emission
    typedef struct packed {
        logic [5:0]                 lead_spaces;
        logic                       has_sign;
        logic [7:0]                 sign_char;
        logic                       has_prefix;
        logic                       upper;
        logic [5:0]                 zeros;
        logic [3:0]                 ndig;
        logic [DIG_MAX-1:0][3:0]    digits;
        logic [5:0]                 trail_spaces;
        logic [5:0]                 total;
    } job_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        begin
            if (d < 4'd10)
            begin
                digit_char = CH_ZERO + {4'b0, d};
            end
            else
            begin
                base = upper ? CH_A_UP : CH_A_LO;
                digit_char = base + {4'b0, d} - 8'd10;
            end
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/pifmt_front.sv
// ----------------------------------------------------------------------------
// pifmt_front
// accepts a conversion request, classifies it, extracts digits one per cycle
// and lays out the field counts
// ----------------------------------------------------------------------------
`default_nettype none

module pifmt_front
    import pifmt_pkg::*;
#(
    parameter int MAX_WIDTH = 48
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire conv_t conversion,
    output logic       job_valid,
    output job_t       job,
    input  wire logic  job_full
);

    localparam int         LIM_I = (MAX_WIDTH < LEN_CAP) ? MAX_WIDTH : LEN_CAP;
    localparam logic [5:0] LIM   = 6'(LIM_I);
    localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]  state_reg, state_next;

    logic [1:0]  kind_reg;
    logic        hex_reg;
    logic        upper_reg;
    logic        pfx_reg;
    logic        has_sign_reg;
    logic [7:0]  sch_reg;
    logic        ljust_reg;
    logic        zpad_reg;
    logic        hasp_reg;
    logic [5:0]  w_reg;
    logic [5:0]  prec_reg;
    logic [31:0] t_reg;
    logic [3:0]  nd_reg;
    logic [DIG_MAX-1:0][3:0] dig_reg;

    // classification of the incoming request
    logic [1:0]  kind_c;
    logic        hex_c;
    logic        upper_c;
    logic        pfx_c;
    logic        has_sign_c;
    logic [7:0]  sch_c;
    logic [31:0] mag_c;
    logic [5:0]  w_c;
    logic [5:0]  prec_c;
    logic        suppress_c;
    logic        accept;

    assign accept = push && !full;
    assign full   = (state_reg != ST_IDLE);

    always_comb
    begin
        kind_c     = KIND_NONE;
        hex_c      = 1'b0;
        upper_c    = 1'b0;
        pfx_c      = 1'b0;
        has_sign_c = 1'b0;
        sch_c      = CH_SPACE;
        mag_c      = conversion.value;
        unique case (conversion.op) inside
            OP_SDEC:
            begin
                kind_c = KIND_NUM;
                if (conversion.value[31])
                begin
                    has_sign_c = 1'b1;
                    sch_c      = CH_MINUS;
                    mag_c      = ~conversion.value + 32'd1;
                end
                else if (conversion.force_plus)
                begin
                    has_sign_c = 1'b1;
                    sch_c      = CH_PLUS;
                end
                else if (conversion.space_sign)
                begin
                    has_sign_c = 1'b1;
                    sch_c      = CH_SPACE;
                end
            end
            OP_UDEC:
            begin
                kind_c = KIND_NUM;
            end
            OP_HEXL, OP_HEXU:
            begin
                kind_c  = KIND_NUM;
                hex_c   = 1'b1;
                upper_c = (conversion.op == OP_HEXU);
                pfx_c   = conversion.alt_form && (conversion.value != 32'd0);
            end
            OP_CHAR:
            begin
                kind_c     = KIND_CHAR;
                has_sign_c = 1'b1;
                sch_c      = conversion.value[7:0];
            end
            OP_PCT:
            begin
                kind_c     = KIND_PCT;
                has_sign_c = 1'b1;
                sch_c      = CH_PCT;
            end
            default:
            begin
                kind_c = KIND_NONE;
            end
        endcase
    end

    assign w_c        = (conversion.width > LIM) ? LIM : conversion.width;
    assign prec_c     = (conversion.precision > LIM) ? LIM : conversion.precision;
    assign suppress_c = (conversion.value == 32'd0) && conversion.has_precision &&
                        (prec_c == 6'd0);

    // one digit per cycle: reciprocal multiply for decimal, nibble shift for hex
    logic [63:0] prod;
    logic [28:0] qdec;
    logic [3:0]  rdec;
    logic [31:0] q_step;
    logic [3:0]  d_step;

    assign prod   = {32'b0, t_reg} * {32'b0, RECIP10};
    assign qdec   = prod[63:35];
    assign rdec   = t_reg[3:0] - 4'((qdec[3:0] << 3) + (qdec[3:0] << 1));
    assign q_step = hex_reg ? {4'b0, t_reg[31:4]} : {3'b0, qdec};
    assign d_step = hex_reg ? t_reg[3:0] : rdec;

    // field layout
    logic [5:0] nd6;
    logic [5:0] prec_zeros;
    logic [6:0] used;
    logic [5:0] extra;
    logic [5:0] char_pad;
    logic [5:0] lsp_c;
    logic [5:0] zeros_c;
    logic [5:0] tsp_c;
    logic [6:0] total_c;

    assign nd6        = {2'b0, nd_reg};
    assign prec_zeros = (hasp_reg && (prec_reg > nd6)) ? (prec_reg - nd6) : 6'd0;
    assign used       = {1'b0, nd6} + {1'b0, prec_zeros} + {6'b0, has_sign_reg} +
                        (pfx_reg ? 7'd2 : 7'd0);
    assign extra      = ({1'b0, w_reg} > used) ? 6'({1'b0, w_reg} - used) : 6'd0;
    assign char_pad   = (w_reg > 6'd1) ? (w_reg - 6'd1) : 6'd0;

    always_comb
    begin
        lsp_c   = 6'd0;
        zeros_c = 6'd0;
        tsp_c   = 6'd0;
        unique case (kind_reg)
            KIND_NUM:
            begin
                zeros_c = prec_zeros;
                if (ljust_reg)
                begin
                    tsp_c = extra;
                end
                else if (zpad_reg && !hasp_reg)
                begin
                    zeros_c = prec_zeros + extra;
                end
                else
                begin
                    lsp_c = extra;
                end
            end
            KIND_CHAR:
            begin
                if (ljust_reg)
                begin
                    tsp_c = char_pad;
                end
                else
                begin
                    lsp_c = char_pad;
                end
            end
            default:
            begin
                lsp_c = 6'd0;
            end
        endcase
    end

    assign total_c = {1'b0, lsp_c} + {6'b0, has_sign_reg} + (pfx_reg ? 7'd2 : 7'd0) +
                     {1'b0, zeros_c} + {1'b0, nd6} + {1'b0, tsp_c};

    assign job_valid        = (state_reg == ST_FIN);
    assign job.lead_spaces  = lsp_c;
    assign job.has_sign     = has_sign_reg;
    assign job.sign_char    = sch_reg;
    assign job.has_prefix   = pfx_reg;
    assign job.upper        = upper_reg;
    assign job.zeros        = zeros_c;
    assign job.ndig         = nd_reg;
    assign job.digits       = dig_reg;
    assign job.trail_spaces = tsp_c;
    assign job.total        = total_c[5:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ((kind_c == KIND_NUM) && !suppress_c) ? ST_CONV : ST_FIN;
                end
            end
            ST_CONV:
            begin
                if (q_step == 32'd0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!job_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nd_reg    <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                nd_reg <= 4'd0;
            end
            else if (state_reg == ST_CONV)
            begin
                nd_reg <= nd_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind_c;
            hex_reg      <= hex_c;
            upper_reg    <= upper_c;
            pfx_reg      <= pfx_c;
            has_sign_reg <= has_sign_c;
            sch_reg      <= sch_c;
            ljust_reg    <= conversion.left_justify;
            zpad_reg     <= conversion.zero_pad;
            hasp_reg     <= conversion.has_precision;
            w_reg        <= w_c;
            prec_reg     <= prec_c;
            t_reg        <= mag_c;
        end
        else if (state_reg == ST_CONV)
        begin
            t_reg           <= q_step;
            dig_reg[nd_reg] <= d_step;
        end
    end

    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (nd_reg < 4'(DIG_MAX)))
        else $error("digit index past buffer");

endmodule

`default_nettype wire

>>> rtl/pifmt_queue.sv
// ----------------------------------------------------------------------------
// pifmt_queue
// short job queue that decouples classification from character emission
// ----------------------------------------------------------------------------
`default_nettype none

module pifmt_queue
    import pifmt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_data,
    output logic      q_full,
    input  wire logic rd_en,
    output job_t      rd_data,
    output logic      q_empty
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QDEPTH))
        else $error("queue count overflow");

endmodule

`default_nettype wire

>>> rtl/pifmt_back.sv
// ----------------------------------------------------------------------------
// pifmt_back
// walks a laid-out field and emits one character per cycle into an output
// register, holding while an unpopped character sits there
// ----------------------------------------------------------------------------
`default_nettype none

module pifmt_back
    import pifmt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire job_t q_data,
    output logic      q_pop,
    output logic      empty,
    input  wire logic pop,
    output result_t   result
);

    logic [5:0] rem_reg;
    logic [5:0] lsp_reg;
    logic       sign_reg;
    logic [1:0] pfx_reg;
    logic [5:0] zeros_reg;
    logic [3:0] nd_reg;
    logic [5:0] tsp_reg;
    logic [7:0] sch_reg;
    logic       upper_reg;
    logic [DIG_MAX-1:0][3:0] dig_reg;

    logic       out_valid_reg;
    result_t    result_reg;

    logic       emit;
    logic [7:0] ch;
    logic [3:0] nd_dec;

    assign q_pop  = (rem_reg == 6'd0) && !q_empty;
    assign emit   = (rem_reg != 6'd0) && (!out_valid_reg || pop);
    assign empty  = !out_valid_reg;
    assign result = result_reg;
    assign nd_dec = nd_reg - 4'd1;

    always_comb
    begin
        if (lsp_reg != 6'd0)
        begin
            ch = CH_SPACE;
        end
        else if (sign_reg)
        begin
            ch = sch_reg;
        end
        else if (pfx_reg == 2'd2)
        begin
            ch = CH_ZERO;
        end
        else if (pfx_reg == 2'd1)
        begin
            ch = upper_reg ? CH_X_UP : CH_X_LO;
        end
        else if (zeros_reg != 6'd0)
        begin
            ch = CH_ZERO;
        end
        else if (nd_reg != 4'd0)
        begin
            ch = digit_char(dig_reg[nd_dec], upper_reg);
        end
        else
        begin
            ch = CH_SPACE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= 6'd0;
            lsp_reg       <= 6'd0;
            sign_reg      <= 1'b0;
            pfx_reg       <= 2'd0;
            zeros_reg     <= 6'd0;
            nd_reg        <= 4'd0;
            tsp_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                rem_reg   <= q_data.total;
                lsp_reg   <= q_data.lead_spaces;
                sign_reg  <= q_data.has_sign;
                pfx_reg   <= q_data.has_prefix ? 2'd2 : 2'd0;
                zeros_reg <= q_data.zeros;
                nd_reg    <= q_data.ndig;
                tsp_reg   <= q_data.trail_spaces;
            end
            else if (emit)
            begin
                rem_reg <= rem_reg - 6'd1;
                if (lsp_reg != 6'd0)
                begin
                    lsp_reg <= lsp_reg - 6'd1;
                end
                else if (sign_reg)
                begin
                    sign_reg <= 1'b0;
                end
                else if (pfx_reg != 2'd0)
                begin
                    pfx_reg <= pfx_reg - 2'd1;
                end
                else if (zeros_reg != 6'd0)
                begin
                    zeros_reg <= zeros_reg - 6'd1;
                end
                else if (nd_reg != 4'd0)
                begin
                    nd_reg <= nd_dec;
                end
                else if (tsp_reg != 6'd0)
                begin
                    tsp_reg <= tsp_reg - 6'd1;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sch_reg   <= q_data.sign_char;
            upper_reg <= q_data.upper;
            dig_reg   <= q_data.digits;
        end
        if (emit)
        begin
            result_reg.out_char <= ch;
            result_reg.last     <= (rem_reg == 6'd1);
        end
    end

    logic [6:0] parts_sum;

    assign parts_sum = {1'b0, lsp_reg} + {6'b0, sign_reg} + {5'b0, pfx_reg} +
                       {1'b0, zeros_reg} + {3'b0, nd_reg} + {1'b0, tsp_reg};

    a_rem_matches: assert property (@(posedge clk) disable iff (!rst_n)
        parts_sum == {1'b0, rem_reg})
        else $error("remaining count out of step with field parts");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (rem_reg == 6'd1)) |=> (out_valid_reg && result_reg.last))
        else $error("final character not marked last");

endmodule

`default_nettype wire

>>> rtl/printf_integer_field_formatter.sv
// ----------------------------------------------------------------------------
// printf_integer_field_formatter
// formats one parsed printf integer conversion into a stream of characters
// ----------------------------------------------------------------------------
// usage:
//   conversion channel: drive conversion and raise push; the request is taken
//   at a clock edge with push high and full low. full stays high while the
//   front is working on a request (classify, digit extraction, layout).
//   result channel: while empty is low, result holds the oldest character;
//   pop takes it. result.last marks the final character of a field. a field
//   that lays out to nothing (unused codes, zero with zero precision, no sign
//   flag and no padding) gives no characters.
// timing:
//   the front yields one digit a cycle from the digit extractor (up to 10
//   decimal, 8 hex digits); char and percent skip digit extraction. the
//   back emits one character a cycle while pop keeps up, after loading
//   each field from the job queue.
// reset: clears front state, job queue, back counters and output valid flag.
// stall: when pop stays low the back holds its character and stops; the
//   four-entry job queue fills, then full holds off new requests.
// ----------------------------------------------------------------------------
`default_nettype none

module printf_integer_field_formatter
    import pifmt_pkg::*;
#(
    parameter int MAX_WIDTH = 48
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire conv_t   conversion,
    output logic         empty,
    input  wire logic    pop,
    output result_t      result
);

    // front to queue
    logic job_valid;
    job_t job;
    logic job_full;

    // queue to back
    logic q_empty;
    logic q_pop;
    job_t q_data;

    // classify the request, extract digits, work out padding counts
    pifmt_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .conversion (conversion),
        .job_valid  (job_valid),
        .job        (job),
        .job_full   (job_full)
    );

    // laid-out fields wait here so the front can run ahead of a stalled back
    pifmt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job),
        .q_full  (job_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    // character emission: spaces, sign, prefix, zeros, digits, spaces
    pifmt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire
